// ----- rtl/tgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types and constants of the touch gesture recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

   // Event kinds carried on the result channel's tuser.
   localparam logic [2:0] EV_PRESS      = 3'd0;
   localparam logic [2:0] EV_DRAG       = 3'd1;
   localparam logic [2:0] EV_TAP        = 3'd2;
   localparam logic [2:0] EV_DOUBLE_TAP = 3'd3;
   localparam logic [2:0] EV_RELEASE    = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] REG_PRESSURE_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_X_OFFSET           = 3'd1;
   localparam logic [2:0] REG_X_SPAN             = 3'd2;
   localparam logic [2:0] REG_Y_OFFSET           = 3'd3;
   localparam logic [2:0] REG_Y_SPAN             = 3'd4;
   localparam logic [2:0] REG_DEBOUNCE_MS        = 3'd5;
   localparam logic [2:0] REG_TAP_MS             = 3'd6;
   localparam logic [2:0] REG_DOUBLE_TAP_MS      = 3'd7;

   // Register reset values.
   localparam logic [9:0]  RST_PRESSURE_THRESHOLD = 10'd512;
   localparam logic [9:0]  RST_X_OFFSET           = 10'd256;
   localparam logic [9:0]  RST_X_SPAN             = 10'd552;
   localparam logic [9:0]  RST_Y_OFFSET           = 10'd240;
   localparam logic [9:0]  RST_Y_SPAN             = 10'd570;
   localparam logic [9:0]  RST_DEBOUNCE_MS        = 10'd20;
   localparam logic [15:0] RST_TAP_MS             = 16'd300;
   localparam logic [15:0] RST_DOUBLE_TAP_MS      = 16'd600;

   // Cell code meaning that no cell has been seen, and the far-away stamp.
   localparam logic [7:0]  NO_CELL   = 8'hFF;
   localparam logic [31:0] FAR_STAMP = 32'h7FFF_FFFF;

   // Status returned by the serial multiply-divide unit.
   typedef struct packed {
      logic done;
      logic sat;
   } tgr_div_status_type;

endpackage

`default_nettype wire

// ----- rtl/tgr_muldiv.sv -----
// ----------------------------------------------------------------------------
// tgr_muldiv
// Bit-serial unit computing (a * b) / d with a saturation flag for quotients
// that do not fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_muldiv #(
   parameter int NW = 10,
   parameter int QW = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [NW-1:0]               a,
   input  wire logic [QW-1:0]               b,
   input  wire logic [NW-1:0]               d,
   output tgr_pkg::tgr_div_status_type      status,
   output logic      [QW-1:0]               q
);
   import tgr_pkg::*;

   localparam int PW = NW + QW;
   localparam int CW = $clog2(QW);

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_MUL  = 2'd1;
   localparam logic [1:0] P_CHK  = 2'd2;
   localparam logic [1:0] P_DIV  = 2'd3;

   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] a_ff, a_in;
   logic [QW-1:0] b_ff, b_in;
   logic [NW-1:0] d_ff, d_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [NW-1:0] r_ff, r_in;
   logic [QW-1:0] q_ff, q_in;
   logic          done_ff, done_in;
   logic          sat_ff, sat_in;

   logic [NW:0]   trial;
   logic [NW:0]   trial_diff;
   logic          trial_ge;
   logic [NW-1:0] hi;

   assign hi         = acc_ff[PW-1:QW];
   assign trial      = {r_ff, acc_ff[QW-1]};
   assign trial_diff = trial - {1'b0, d_ff};
   assign trial_ge   = trial >= {1'b0, d_ff};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      acc_in   = acc_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      sat_in   = sat_ff;
      unique case (phase_ff)
         P_IDLE: begin
            if (start) begin
               a_in     = a;
               b_in     = b;
               d_in     = d;
               acc_in   = '0;
               cnt_in   = CW'(QW - 1);
               sat_in   = 1'b0;
               phase_in = P_MUL;
            end
         end
         P_MUL: begin
            // Shift-add, multiplier bits taken most significant first.
            acc_in = {acc_ff[PW-2:0], 1'b0} + (b_ff[QW-1] ? PW'(a_ff) : '0);
            b_in   = {b_ff[QW-2:0], 1'b0};
            if (cnt_ff == '0) begin
               phase_in = P_CHK;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         P_CHK: begin
            // The quotient needs more than QW bits exactly when the upper
            // part of the product already reaches the divisor.
            if (hi >= d_ff) begin
               sat_in   = 1'b1;
               q_in     = '1;
               done_in  = 1'b1;
               phase_in = P_IDLE;
            end else begin
               r_in     = hi;
               cnt_in   = CW'(QW - 1);
               phase_in = P_DIV;
            end
         end
         P_DIV: begin
            r_in   = trial_ge ? trial_diff[NW-1:0] : trial[NW-1:0];
            q_in   = {q_ff[QW-2:0], trial_ge};
            acc_in = {acc_ff[PW-2:0], 1'b0};
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               phase_in = P_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         sat_ff   <= sat_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      acc_ff <= acc_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
   end

   assign status.done = done_ff;
   assign status.sat  = sat_ff;
   assign q           = q_ff;

endmodule

`default_nettype wire

// ----- rtl/touch_gesture_recognizer_core.sv -----
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_core
// Turns touch panel scans into press, drag, tap, double tap and release events.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the req_ channel is one panel scan (time stamp, pressure and raw
// x/y readings). Each scan produces zero, one or two beats on the rsp_ channel;
// rsp_tlast marks the final beat of a scan and rsp_tuser holds the event kind.
// Configuration registers are written through csr_we/csr_index/csr_wdata while
// the block is idle and take effect for the next scan.
// The block works on one scan at a time. A touched scan runs four operations
// (x, y, column, row) through one shared bit-serial multiply-divide unit, QW
// being the bit width of SCALE_MAX. Results leave through a single output
// register, so a new scan is accepted while the last beat still waits; when
// the receiver stalls the block holds in front of the register until it
// drains. Reset restores the register defaults, clears the touch state and
// empties the output register; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_recognizer_core #(
   parameter int SCALE_MAX = 1023,
   parameter int COLUMNS   = 10,
   parameter int ROWS      = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Scan channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // now_ms[31:0], pressure, raw_x, raw_y, zero pad
   // Event channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // pos_x, pos_y, grid_column, grid_row, zero pad
   output logic [2:0]       rsp_tuser,   // event_kind
   output logic             rsp_tlast,   // last_of_run
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import tgr_pkg::*;

   // Width of a calibrated value and of the numerator and divisor of the unit.
   localparam int QW = $clog2(SCALE_MAX + 1);
   localparam int NW = (QW > 10) ? QW : 10;
   localparam int YW = NW + 2;

   localparam logic [QW-1:0] SM_Q    = QW'(SCALE_MAX);
   localparam logic [NW-1:0] SM_N    = NW'(SCALE_MAX);
   localparam logic [QW-1:0] COL_MAX = QW'(COLUMNS - 1);
   localparam logic [QW-1:0] ROW_MAX = QW'(ROWS - 1);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_CHECK      = 4'd1;
   localparam logic [3:0] S_OP_START   = 4'd2;
   localparam logic [3:0] S_OP_WAIT    = 4'd3;
   localparam logic [3:0] S_TOUCH_EMIT = 4'd4;
   localparam logic [3:0] S_REL_DBL    = 4'd5;
   localparam logic [3:0] S_REL_TAP    = 4'd6;
   localparam logic [3:0] S_REL_GEST   = 4'd7;
   localparam logic [3:0] S_REL_EMIT   = 4'd8;

   localparam logic [1:0] OP_X   = 2'd0;
   localparam logic [1:0] OP_Y   = 2'd1;
   localparam logic [1:0] OP_COL = 2'd2;
   localparam logic [1:0] OP_ROW = 2'd3;

   // Configuration registers.
   logic [9:0]  thr_ff, x_offset_ff, x_span_ff, y_offset_ff, y_span_ff, debounce_ff;
   logic [15:0] tap_ms_ff, double_tap_ms_ff;

   // Control and scan registers.
   logic [3:0]  state_ff, state_in;
   logic [1:0]  op_ff;
   logic [31:0] now_ff;
   logic [9:0]  pressure_ff, raw_x_ff, raw_y_ff;
   logic [QW-1:0] x_ff, y_ff;
   logic [3:0]  col_ff, row_ff;
   logic        dbl_ff, tap_ff;

   // Gesture state.
   logic        is_touched_ff;
   logic [7:0]  press_cell_ff, latest_cell_ff;
   logic [9:0]  latest_x_ff, latest_y_ff;
   logic [31:0] press_stamp_ff, tap_stamp_ff, release_stamp_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic [2:0]  rsp_kind_ff;
   logic        rsp_last_ff;

   // Config writes land directly; user writes only while the block is idle; unchecked.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff           <= RST_PRESSURE_THRESHOLD;
         x_offset_ff      <= RST_X_OFFSET;
         x_span_ff        <= RST_X_SPAN;
         y_offset_ff      <= RST_Y_OFFSET;
         y_span_ff        <= RST_Y_SPAN;
         debounce_ff      <= RST_DEBOUNCE_MS;
         tap_ms_ff        <= RST_TAP_MS;
         double_tap_ms_ff <= RST_DOUBLE_TAP_MS;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PRESSURE_THRESHOLD: thr_ff           <= csr_wdata[9:0];
            REG_X_OFFSET:           x_offset_ff      <= csr_wdata[9:0];
            REG_X_SPAN:             x_span_ff        <= csr_wdata[9:0];
            REG_Y_OFFSET:           y_offset_ff      <= csr_wdata[9:0];
            REG_Y_SPAN:             y_span_ff        <= csr_wdata[9:0];
            REG_DEBOUNCE_MS:        debounce_ff      <= csr_wdata[9:0];
            REG_TAP_MS:             tap_ms_ff        <= csr_wdata;
            REG_DOUBLE_TAP_MS:      double_tap_ms_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // A scan counts as touched when the pressure reading is below threshold.
   logic touched_scan;
   assign touched_scan = pressure_ff < thr_ff;

   // One shared 32-bit time comparator: (now - stamp) < limit, modulo 2^32.
   // The stamp and limit change with the state that asks the question.
   logic [31:0] stamp_sel, limit_sel, elapsed;
   logic        in_window;

   always_comb begin
      case (state_ff)
         S_CHECK: begin
            stamp_sel = touched_scan ? release_stamp_ff : press_stamp_ff;
            limit_sel = 32'(debounce_ff);
         end
         S_REL_DBL: begin
            stamp_sel = tap_stamp_ff;
            limit_sel = 32'(double_tap_ms_ff);
         end
         default: begin
            stamp_sel = press_stamp_ff;
            limit_sel = 32'(tap_ms_ff);
         end
      endcase
   end

   assign elapsed   = now_ff - stamp_sel;
   assign in_window = elapsed < limit_sel;

   // Operands for the multiply-divide unit. A numerator that is zero or
   // negative is fed as zero so the quotient comes out zero; a zero span acts
   // as one.
   logic [10:0]   numer_x;
   logic [YW-1:0] numer_y;
   logic [NW-1:0] op_a, op_d;
   logic [QW-1:0] op_b;

   assign numer_x = {1'b0, raw_x_ff} - {1'b0, x_offset_ff};
   assign numer_y = {2'b00, SM_N} - YW'(raw_y_ff) - YW'(y_offset_ff);

   always_comb begin
      unique case (op_ff)
         OP_X: begin
            op_a = numer_x[10] ? '0 : NW'(numer_x[9:0]);
            op_b = SM_Q;
            op_d = NW'((x_span_ff == 10'd0) ? 10'd1 : x_span_ff);
         end
         OP_Y: begin
            op_a = numer_y[YW-1] ? '0 : numer_y[NW-1:0];
            op_b = SM_Q;
            op_d = NW'((y_span_ff == 10'd0) ? 10'd1 : y_span_ff);
         end
         OP_COL: begin
            op_a = NW'(x_ff);
            op_b = QW'(COLUMNS);
            op_d = SM_N;
         end
         default: begin
            op_a = NW'(y_ff);
            op_b = QW'(ROWS);
            op_d = SM_N;
         end
      endcase
   end

   tgr_div_status_type div_stat;
   logic [QW-1:0]      div_q;
   logic               div_start;

   assign div_start = state_ff == S_OP_START;

   tgr_muldiv #(
      .NW (NW),
      .QW (QW)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .a      (op_a),
      .b      (op_b),
      .d      (op_d),
      .status (div_stat),
      .q      (div_q)
   );

   // Clamp the quotient: calibration saturates at SCALE_MAX, the grid index at
   // the last column or row.
   logic [QW-1:0] cal_val, col_val, row_val;
   assign cal_val = (div_stat.sat || div_q > SM_Q) ? SM_Q : div_q;
   assign col_val = (div_q > COL_MAX) ? COL_MAX : div_q;
   assign row_val = (div_q > ROW_MAX) ? ROW_MAX : div_q;

   // The output register can take a beat when it is empty or being drained.
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   logic [7:0] new_cell, latest_col_row;
   logic       same_cell;
   assign new_cell  = {row_ff, col_ff};
   assign same_cell = latest_cell_ff == press_cell_ff;
   assign latest_col_row = latest_cell_ff;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (touched_scan) begin
               state_in = in_window ? S_IDLE : S_OP_START;
            end else begin
               state_in = (!is_touched_ff || in_window) ? S_IDLE : S_REL_DBL;
            end
         end
         S_OP_START: begin
            state_in = S_OP_WAIT;
         end
         S_OP_WAIT: begin
            if (div_stat.done) begin
               state_in = (op_ff == OP_ROW) ? S_TOUCH_EMIT : S_OP_START;
            end
         end
         S_TOUCH_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_REL_DBL: begin
            state_in = S_REL_TAP;
         end
         S_REL_TAP: begin
            state_in = S_REL_GEST;
         end
         S_REL_GEST: begin
            if (!(dbl_ff || tap_ff) || out_free) begin
               state_in = S_REL_EMIT;
            end
         end
         S_REL_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   logic load_out;
   assign load_out = out_free &&
                     ((state_ff == S_TOUCH_EMIT) || (state_ff == S_REL_EMIT) ||
                      ((state_ff == S_REL_GEST) && (dbl_ff || tap_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         op_ff            <= OP_X;
         is_touched_ff    <= 1'b0;
         press_cell_ff    <= NO_CELL;
         latest_cell_ff   <= NO_CELL;
         latest_x_ff      <= '0;
         latest_y_ff      <= '0;
         press_stamp_ff   <= FAR_STAMP;
         tap_stamp_ff     <= FAR_STAMP;
         release_stamp_ff <= FAR_STAMP;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_CHECK: begin
               op_ff <= OP_X;
            end
            S_OP_WAIT: begin
               if (div_stat.done) begin
                  op_ff <= op_ff + 2'd1;
               end
            end
            S_TOUCH_EMIT: begin
               if (out_free) begin
                  latest_x_ff    <= 10'(x_ff);
                  latest_y_ff    <= 10'(y_ff);
                  latest_cell_ff <= new_cell;
                  if (!is_touched_ff) begin
                     // First touched scan: this is a press.
                     is_touched_ff  <= 1'b1;
                     press_cell_ff  <= new_cell;
                     press_stamp_ff <= now_ff;
                     if (new_cell != press_cell_ff) begin
                        tap_stamp_ff <= FAR_STAMP;
                     end
                  end
               end
            end
            S_REL_GEST: begin
               if (out_free && (dbl_ff || tap_ff)) begin
                  tap_stamp_ff <= dbl_ff ? FAR_STAMP : now_ff;
               end
            end
            S_REL_EMIT: begin
               if (out_free) begin
                  release_stamp_ff <= now_ff;
                  is_touched_ff    <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         now_ff      <= req_tdata[31:0];
         pressure_ff <= req_tdata[41:32];
         raw_x_ff    <= req_tdata[51:42];
         raw_y_ff    <= req_tdata[61:52];
      end

      if (state_ff == S_OP_WAIT && div_stat.done) begin
         case (op_ff)
            OP_X:    x_ff   <= cal_val;
            OP_Y:    y_ff   <= cal_val;
            OP_COL:  col_ff <= col_val[3:0];
            default: row_ff <= row_val[3:0];
         endcase
      end

      // A double tap takes priority over a plain tap.
      if (state_ff == S_REL_DBL) begin
         dbl_ff <= in_window && same_cell;
      end
      if (state_ff == S_REL_TAP) begin
         tap_ff <= in_window && same_cell && !dbl_ff;
      end

      if (load_out) begin
         case (state_ff)
            S_TOUCH_EMIT: begin
               rsp_kind_ff <= is_touched_ff ? EV_DRAG : EV_PRESS;
               rsp_data_ff <= {5'd0, row_ff[2:0], col_ff, 10'(y_ff), 10'(x_ff)};
               rsp_last_ff <= 1'b1;
            end
            S_REL_GEST: begin
               rsp_kind_ff <= dbl_ff ? EV_DOUBLE_TAP : EV_TAP;
               rsp_data_ff <= {5'd0, latest_col_row[6:4], latest_col_row[3:0],
                               latest_y_ff, latest_x_ff};
               rsp_last_ff <= 1'b0;
            end
            default: begin
               rsp_kind_ff <= EV_RELEASE;
               rsp_data_ff <= '0;
               rsp_last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A release beat carries no position and always closes its scan.
   a_release_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_RELEASE |-> rsp_tdata == '0 && rsp_tlast)
      else $error("release beat with position or without tlast");

   // Tap and double tap beats never carry tlast: a release beat of the same scan follows.
   a_gesture_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_TAP || rsp_tuser == EV_DOUBLE_TAP) |-> !rsp_tlast)
      else $error("tap beat marked as last of scan");

   // The divider only reports completion while the sequencer waits for it.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_OP_WAIT)
      else $error("divider finished outside of its wait state");

   // The touch flag is only set while a press beat goes out.
   a_touch_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(is_touched_ff) |-> $past(state_ff) == S_TOUCH_EMIT && rsp_tvalid &&
                               rsp_tuser == EV_PRESS)
      else $error("touch state set without a press beat");

endmodule

`default_nettype wire
